>>> rtl/fdx_pkg.sv
// ----------------------------------------------------------------------------
// fdx_pkg
// Shared types and constants of the frame deframer with XOR checksum.
// ----------------------------------------------------------------------------
package fdx_pkg;

  // Widths of the fixed fields
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 11;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned CntW   = 32;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSyncFirst  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSyncSecond = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLengthLimit = 2'd2;

  // Per-byte event from the receiver
  typedef struct packed {
    logic              wr_en;        // payload byte to store
    logic [LenW-1:0]   wr_count;     // payload position of that byte
    logic              frame_good;
    logic              checksum_bad;
    logic              length_bad;
  } fdx_event_t;

  // Receiver status shown with every result
  typedef struct packed {
    logic [ByteW-1:0] frame_type;
    logic [LenW-1:0]  frame_length;
    logic [CntW-1:0]  good_count;
    logic [CntW-1:0]  bad_checksum_count;
    logic [CntW-1:0]  bad_length_count;
  } fdx_status_t;

endpackage

>>> rtl/fdx_rx.sv
// ----------------------------------------------------------------------------
// fdx_rx
// Receive sequencer: sync hunt, header decode, length check, payload XOR
// and checksum compare, plus the frame statistics counters.
// ----------------------------------------------------------------------------
module fdx_rx #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,       // line byte accepted
  input  logic [fdx_pkg::ByteW-1:0]    data_byte_i,
  input  logic [fdx_pkg::ByteW-1:0]    sync_first_i,
  input  logic [fdx_pkg::ByteW-1:0]    sync_second_i,
  input  logic [fdx_pkg::LenW-1:0]     length_limit_i,
  output fdx_pkg::fdx_event_t          event_o,
  output fdx_pkg::fdx_status_t         status_o
);
  import fdx_pkg::*;

  localparam logic [2:0] PhSync1   = 3'd0;
  localparam logic [2:0] PhSync2   = 3'd1;
  localparam logic [2:0] PhType    = 3'd2;
  localparam logic [2:0] PhLenLo   = 3'd3;
  localparam logic [2:0] PhLenHi   = 3'd4;
  localparam logic [2:0] PhPayload = 3'd5;
  localparam logic [2:0] PhCheck   = 3'd6;

  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  logic [2:0]       phase_q, phase_d;
  logic [ByteW-1:0] type_q, type_d;
  logic [ByteW-1:0] len_lo_q, len_lo_d;
  logic [LenW-1:0]  acc_len_q, acc_len_d;
  logic [LenW-1:0]  rcount_q, rcount_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [CntW-1:0]  good_q, good_d;
  logic [CntW-1:0]  bad_sum_q, bad_sum_d;
  logic [CntW-1:0]  bad_len_q, bad_len_d;

  logic [15:0]      len_full;
  logic             len_over;
  logic [LenW:0]    rcount_inc;

  assign len_full   = {data_byte_i, len_lo_q};
  assign len_over   = (len_full > {5'd0, length_limit_i}) || (len_full > MaxLen);
  assign rcount_inc = {1'b0, rcount_q} + 12'd1;

  // Next state for one line byte
  always_comb begin
    phase_d   = phase_q;
    type_d    = type_q;
    len_lo_d  = len_lo_q;
    acc_len_d = acc_len_q;
    rcount_d  = rcount_q;
    xor_d     = xor_q;
    good_d    = good_q;
    bad_sum_d = bad_sum_q;
    bad_len_d = bad_len_q;
    event_o   = '0;
    event_o.wr_count = rcount_q;
    unique case (phase_q)
      PhSync1: begin
        if (data_byte_i == sync_first_i) phase_d = PhSync2;
      end
      PhSync2: begin
        // second sync wins; a repeated first sync keeps waiting
        if (data_byte_i == sync_second_i) phase_d = PhType;
        else if (data_byte_i != sync_first_i) phase_d = PhSync1;
      end
      PhType: begin
        type_d  = data_byte_i;
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        len_lo_d = data_byte_i;
        phase_d  = PhLenHi;
      end
      PhLenHi: begin
        if (len_over) begin
          bad_len_d = bad_len_q + 32'd1;
          event_o.length_bad = 1'b1;
          phase_d = PhSync1;
        end else begin
          acc_len_d = len_full[LenW-1:0];
          rcount_d  = '0;
          xor_d     = '0;
          phase_d   = (len_full == 16'd0) ? PhCheck : PhPayload;
        end
      end
      PhPayload: begin
        event_o.wr_en = 1'b1;
        xor_d    = xor_q ^ data_byte_i;
        rcount_d = rcount_inc[LenW-1:0];
        if (rcount_inc >= {1'b0, acc_len_q}) phase_d = PhCheck;
      end
      PhCheck: begin
        phase_d = PhSync1;
        if (data_byte_i == xor_q) begin
          good_d = good_q + 32'd1;
          event_o.frame_good = 1'b1;
        end else begin
          bad_sum_d = bad_sum_q + 32'd1;
          event_o.checksum_bad = 1'b1;
        end
      end
      default: phase_d = PhSync1;
    endcase
  end

  // Advance on every pushed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhSync1;
      type_q    <= '0;
      len_lo_q  <= '0;
      acc_len_q <= '0;
      rcount_q  <= '0;
      xor_q     <= '0;
      good_q    <= '0;
      bad_sum_q <= '0;
      bad_len_q <= '0;
    end else if (push_i) begin
      phase_q   <= phase_d;
      type_q    <= type_d;
      len_lo_q  <= len_lo_d;
      acc_len_q <= acc_len_d;
      rcount_q  <= rcount_d;
      xor_q     <= xor_d;
      good_q    <= good_d;
      bad_sum_q <= bad_sum_d;
      bad_len_q <= bad_len_d;
    end
  end

  assign status_o.frame_type         = type_q;
  assign status_o.frame_length       = acc_len_q;
  assign status_o.good_count         = good_q;
  assign status_o.bad_checksum_count = bad_sum_q;
  assign status_o.bad_length_count   = bad_len_q;

endmodule

>>> rtl/frame_deframer_xor_checksum_top.sv
// ----------------------------------------------------------------------------
// frame_deframer_xor_checksum_top
// Byte-serial deframer for length-prefixed frames with an XOR checksum,
// payload store with indexed read-back and frame statistics.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake               Contents
//  s_axis    in   tvalid/tready           tuser: mode; tdata: byte, index
//  m_axis    out  tvalid/tready           tuser: flags; tdata: status, read
//  cfg       in   cfg_valid_i/cfg_ready_o index and value of one register
//
//  One request per cycle is taken while the output register is empty or its
//  result is being taken; the result appears in the output register in the
//  following cycle, read data coming from the registered store port.
//  Reset clears the receiver state and counters; the store is not cleared.
//  A stalled result holds the input side only while it is not taken.
// ----------------------------------------------------------------------------
module frame_deframer_xor_checksum_top #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input requests
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [23:0]                  s_axis_tdata,  // [7:0] data_byte, [17:8] read_index
  input  logic [0:0]                   s_axis_tuser,  // [0] mode
  // results
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [127:0]                 m_axis_tdata,  // [7:0] frame_type,
                                                      // [18:8] frame_length,
                                                      // [26:19] read_data,
                                                      // [58:27] good_count,
                                                      // [90:59] bad_checksum_count,
                                                      // [122:91] bad_length_count
  output logic [2:0]                   m_axis_tuser,  // [0] frame_good,
                                                      // [1] checksum_bad, [2] length_bad
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [fdx_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fdx_pkg::LenW-1:0]     cfg_data_i
);
  import fdx_pkg::*;

  localparam int unsigned AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [16:0] MaxPos = 17'(MAX_PAYLOAD);

  logic [ByteW-1:0] sync_first_q, sync_second_q;
  logic [LenW-1:0]  length_limit_q;

  logic             accept;
  logic             mode;
  logic [ByteW-1:0] data_byte;
  logic [IdxW-1:0]  read_index;
  logic             push;
  logic             rd_en;
  logic             rd_ok;
  logic [16:0]      idx_ext, wcount_ext;
  logic             wr_en;

  fdx_event_t       ev;
  fdx_status_t      status;

  logic             out_valid_q;
  logic [2:0]       flags_q;
  logic             rd_ok_q;
  logic [ByteW-1:0] rd_data_q;
  logic [ByteW-1:0] store_q [MAX_PAYLOAD];

  assign mode       = s_axis_tuser[0];
  assign data_byte  = s_axis_tdata[7:0];
  assign read_index = s_axis_tdata[17:8];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push          = accept && !mode;
  assign rd_en         = accept && mode;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q   <= 8'd170;
      sync_second_q  <= 8'd85;
      length_limit_q <= 11'd1024;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgSyncFirst:   sync_first_q   <= cfg_data_i[ByteW-1:0];
        CfgSyncSecond:  sync_second_q  <= cfg_data_i[ByteW-1:0];
        CfgLengthLimit: length_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fdx_rx #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_rx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .data_byte_i   (data_byte),
    .sync_first_i  (sync_first_q),
    .sync_second_i (sync_second_q),
    .length_limit_i(length_limit_q),
    .event_o       (ev),
    .status_o      (status)
  );

  // Store bounds: write below the store depth, read below the latest length and the store depth
  assign idx_ext    = {7'd0, read_index};
  assign wcount_ext = {6'd0, ev.wr_count};
  assign wr_en      = push && ev.wr_en && (wcount_ext < MaxPos);
  assign rd_ok      = ({1'b0, read_index} < status.frame_length) && (idx_ext < MaxPos);

  // Payload store with registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) store_q[wcount_ext[AddrW-1:0]] <= data_byte;
    if (rd_en) rd_data_q <= store_q[idx_ext[AddrW-1:0]];
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      flags_q <= push ? {ev.length_bad, ev.checksum_bad, ev.frame_good} : 3'b000;
      rd_ok_q <= mode && rd_ok;
    end
  end

  // Status registers only move on the next accepted request, so show them directly
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = flags_q;
  assign m_axis_tdata  = {5'd0,
                          status.bad_length_count,
                          status.bad_checksum_count,
                          status.good_count,
                          rd_ok_q ? rd_data_q : 8'd0,
                          status.frame_length,
                          status.frame_type};

endmodule

>>> bench/tb_frame_deframer_xor_checksum_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_deframer_xor_checksum_top
// Self-checking bench for the byte-serial deframer. A behavioural model of
// the receiver runs beside the block. Each request it accepts is predicted
// into one expected status word, and every result is compared field by
// field. The stimulus is a directed opening, then a single frame of the
// largest size, then runs of random frames, broken headers, noise and
// interleaved store reads. These run under several register settings, with
// random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_frame_deframer_xor_checksum_top;

  import fdx_pkg::*;

  localparam int unsigned MaxPayload  = 1024;
  localparam int unsigned DrainCycles = 3;
  localparam longint      TimeoutNs   = 64'd10_000_000;

  // Register index beyond the list; the block must ignore it
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, GET_TYPE, GET_LEN_LO, GET_LEN_HI, GET_PAYLOAD, GET_CHECK
  } rx_phase_e;

  typedef struct packed {
    logic              good;
    logic              sum_bad;
    logic              len_bad;
    logic [ByteW-1:0]  ftype;
    logic [LenW-1:0]   flen;
    logic [ByteW-1:0]  rdata;
    logic [CntW-1:0]   n_good;
    logic [CntW-1:0]   n_sum_bad;
    logic [CntW-1:0]   n_len_bad;
  } rx_status_t;

  // Clock, reset and the block's ports
  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_mode  = 1'b0;
  logic [ByteW-1:0]    s_byte  = '0;
  logic [IdxW-1:0]     s_idx   = '0;
  logic                rx_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [LenW-1:0]     cfg_data  = '0;

  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata;
  logic                m_axis_tvalid;
  logic [127:0]        m_axis_tdata;
  logic [2:0]          m_axis_tuser;
  logic                cfg_ready_o;

  assign s_axis_tdata = {6'b0, s_idx, s_byte};

  // Bench controls
  bit  tx_idle_en = 1'b1;
  bit  rx_idle_en = 1'b1;
  bit  read_mix   = 1'b0;
  int  rx_hold    = 0;
  int  rx_stall   = 0;
  int  n_items    = 0;
  int  n_errors   = 0;

  // Receiver model state and its copy of the registers
  rx_phase_e         cur_phase = HUNT_FIRST;
  logic [ByteW-1:0]  hdr_type  = '0;
  logic [15:0]       hdr_len   = '0;
  logic [LenW-1:0]   taken_len = '0;
  logic [LenW-1:0]   pay_count = '0;
  logic [ByteW-1:0]  pay_xor   = '0;
  logic [ByteW-1:0]  pay_mem [MaxPayload];
  bit                mem_written [MaxPayload];
  logic [CntW-1:0]   n_good    = '0;
  logic [CntW-1:0]   n_sum_bad = '0;
  logic [CntW-1:0]   n_len_bad = '0;
  logic [ByteW-1:0]  sync_a  = 8'd170;
  logic [ByteW-1:0]  sync_b  = 8'd85;
  logic [LenW-1:0]   len_cap = 11'd1024;

  rx_status_t pending_q [$];

  frame_deframer_xor_checksum_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_mode),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (rx_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Largest length a header may carry under the present setting
  function automatic logic [LenW-1:0] eff_limit();
    return (len_cap > MaxPayload) ? LenW'(MaxPayload) : len_cap;
  endfunction

  // Advance the receiver model by one request and build its status
  function automatic void predict_byte(input bit mode, input logic [ByteW-1:0] b,
                                       input logic [IdxW-1:0] idx, output rx_status_t r);
    r = '0;
    if (mode) begin
      if (idx < taken_len) r.rdata = pay_mem[idx];
    end else begin
      case (cur_phase)
        HUNT_FIRST: begin
          if (b == sync_a) cur_phase = HUNT_SECOND;
        end
        HUNT_SECOND: begin
          // a repeated first sync byte keeps waiting; the second sync wins a tie
          if (b == sync_b) cur_phase = GET_TYPE;
          else if (b != sync_a) cur_phase = HUNT_FIRST;
        end
        GET_TYPE: begin
          hdr_type  = b;
          cur_phase = GET_LEN_LO;
        end
        GET_LEN_LO: begin
          hdr_len   = {8'h00, b};
          cur_phase = GET_LEN_HI;
        end
        GET_LEN_HI: begin
          hdr_len = {b, hdr_len[7:0]};
          if (hdr_len > eff_limit()) begin
            n_len_bad++;
            r.len_bad = 1'b1;
            cur_phase = HUNT_FIRST;
          end else begin
            taken_len = hdr_len[LenW-1:0];
            pay_count = '0;
            pay_xor   = '0;
            cur_phase = (hdr_len == 0) ? GET_CHECK : GET_PAYLOAD;
          end
        end
        GET_PAYLOAD: begin
          if (pay_count < MaxPayload) begin
            pay_mem[pay_count[IdxW-1:0]]     = b;
            mem_written[pay_count[IdxW-1:0]] = 1'b1;
          end
          pay_xor = pay_xor ^ b;
          pay_count++;
          if (pay_count >= hdr_len) cur_phase = GET_CHECK;
        end
        GET_CHECK: begin
          cur_phase = HUNT_FIRST;
          if (b == pay_xor) begin
            n_good++;
            r.good = 1'b1;
          end else begin
            n_sum_bad++;
            r.sum_bad = 1'b1;
          end
        end
        default: cur_phase = HUNT_FIRST;
      endcase
    end
    r.ftype     = hdr_type;
    r.flen      = taken_len;
    r.n_good    = n_good;
    r.n_sum_bad = n_sum_bad;
    r.n_len_bad = n_len_bad;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Choose a read position that never touches a store entry left unwritten
  function automatic bit pick_read_index(output logic [IdxW-1:0] idx);
    idx = IdxW'($urandom);
    if (idx >= taken_len || mem_written[idx]) return 1'b1;
    if (taken_len < MaxPayload) begin
      idx = IdxW'($urandom_range(MaxPayload - 1, taken_len));
      return 1'b1;
    end
    for (int k = 0; k < MaxPayload; k++) begin
      if (mem_written[k]) begin
        idx = IdxW'(k);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Offer one request, hold it until taken, then record its expected status
  task automatic offer_request(input bit mode, input logic [ByteW-1:0] b,
                               input logic [IdxW-1:0] idx);
    int g;
    rx_status_t r;
    g = tx_idle_en ? gap_len() : 0;
    if (g > 0) begin
      s_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_mode  <= mode;
    s_byte  <= b;
    s_idx   <= idx;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_byte(mode, b, idx, r);
    pending_q.push_back(r);
    n_items++;
  endtask

  // Push one line byte, now and then preceded by a store read
  task automatic push_line(input logic [ByteW-1:0] b);
    logic [IdxW-1:0] idx;
    if (read_mix && $urandom_range(9, 0) == 0 && pick_read_index(idx))
      offer_request(1'b1, ByteW'($urandom), idx);
    offer_request(1'b0, b, IdxW'($urandom));
  endtask

  // Send sync pair, header and, when the length passes, payload and checksum
  task automatic send_frame(input logic [ByteW-1:0] ftype, input logic [15:0] len,
                            input bit corrupt);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] p;
    sum = '0;
    push_line(sync_a);
    push_line(sync_b);
    push_line(ftype);
    push_line(len[7:0]);
    push_line(len[15:8]);
    if (len <= eff_limit()) begin
      repeat (len) begin
        p   = ByteW'($urandom);
        sum = sum ^ p;
        push_line(p);
      end
      push_line(corrupt ? sum ^ ByteW'($urandom_range(255, 1)) : sum);
    end
  endtask

  // Payload length that the present limit accepts, mostly short
  function automatic logic [15:0] good_len();
    int unsigned lim;
    int r;
    lim = 32'(eff_limit());
    r   = $urandom_range(99, 0);
    if (r < 80) return 16'($urandom_range((lim < 12) ? lim : 12, 0));
    if (r < 97) return 16'($urandom_range((lim < 48) ? lim : 48, 0));
    return 16'($urandom_range((lim < 160) ? lim : 160, 0));
  endfunction

  // Header length just or far above the present limit
  function automatic logic [15:0] over_len();
    int unsigned lim;
    lim = 32'(eff_limit());
    if ($urandom_range(9, 0) < 3) return 16'(lim + 1);
    return 16'($urandom_range(65535, lim + 1));
  endfunction

  // Mix of good frames, bad checksums, long headers, sync repeats and noise
  task automatic run_traffic(input int n);
    int stop_at;
    int r;
    logic [ByteW-1:0] b;
    stop_at = n_items + n;
    while (n_items < stop_at) begin
      r = $urandom_range(99, 0);
      if (r < 70) begin
        send_frame(ByteW'($urandom), good_len(), 1'b0);
      end else if (r < 78) begin
        send_frame(ByteW'($urandom), good_len(), 1'b1);
      end else if (r < 84) begin
        send_frame(ByteW'($urandom), over_len(), 1'b0);
      end else if (r < 89) begin
        repeat ($urandom_range(3, 1)) push_line(sync_a);
        send_frame(ByteW'($urandom), good_len(), 1'b0);
      end else if (r < 94) begin
        // first sync byte followed by a stray byte drops back to the hunt
        push_line(sync_a);
        b = ByteW'($urandom);
        while (b == sync_a || b == sync_b) b = ByteW'($urandom);
        push_line(b);
      end else begin
        repeat ($urandom_range(4, 1))
          push_line(($urandom_range(2, 0) == 0) ? sync_a : ByteW'($urandom));
      end
    end
  endtask

  // Drop the request line and let every pending result arrive
  task automatic wait_idle();
    s_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [LenW-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgSyncFirst:   sync_a  = value[7:0];
      CfgSyncSecond:  sync_b  = value[7:0];
      CfgLengthLimit: len_cap = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    logic [ByteW-1:0] line [$];
    offer_request(1'b1, 8'hFF, 10'h3FF);
    // stray byte after the first sync, then a repeated first sync
    line = '{8'hAA, 8'h12, 8'hAA, 8'hAA, 8'h55, 8'hFF, 8'h02, 8'h00, 8'h00, 8'hFF, 8'hFF};
    foreach (line[i]) push_line(line[i]);
    offer_request(1'b1, 8'h00, 10'd1);
    offer_request(1'b1, 8'h00, 10'd2);
    // all-ones length, then an empty frame with a non-zero checksum
    line = '{8'hAA, 8'h55, 8'h00, 8'hFF, 8'hFF, 8'hAA, 8'h55, 8'h5A, 8'h00, 8'h00, 8'h01};
    foreach (line[i]) push_line(line[i]);
  endtask

  task automatic test_largest_frame();
    send_frame(8'h81, 16'd1025, 1'b0);
    send_frame(8'h7E, 16'd1024, 1'b0);
    read_mix = 1'b1;
    offer_request(1'b1, 8'h00, 10'd0);
    offer_request(1'b1, 8'hFF, 10'h3FF);
  endtask

  task automatic test_random_traffic();
    run_traffic(60);
  endtask

  task automatic test_no_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_traffic(40);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Hold the output off for a long stretch while requests keep coming
  task automatic test_back_pressure();
    tx_idle_en = 1'b0;
    rx_hold    = 200;
    run_traffic(40);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_equal_sync();
    logic [ByteW-1:0] v;
    v = ByteW'($urandom);
    write_reg(CfgSyncFirst, {3'b101, v});
    write_reg(CfgSyncSecond, {3'b010, v});
    write_reg(CfgLengthLimit, 11'd0);
    run_traffic(20);
  endtask

  // Limit above the store size: the store size still caps the length
  task automatic test_limit_cap();
    write_reg(CfgSyncFirst, 11'h7FF);
    write_reg(CfgSyncSecond, 11'h000);
    write_reg(CfgLengthLimit, 11'h7FF);
    send_frame(8'h00, 16'd1025, 1'b0);
    send_frame(8'hFF, 16'd2047, 1'b0);
    run_traffic(20);
  endtask

  task automatic test_small_limit();
    logic [LenW-1:0] lim;
    lim = LenW'($urandom_range(16, 1));
    write_reg(CfgSyncFirst, LenW'($urandom));
    write_reg(CfgSyncSecond, LenW'($urandom));
    write_reg(CfgLengthLimit, lim);
    write_reg(CfgUnused, LenW'($urandom));
    send_frame(ByteW'($urandom), 16'(lim), 1'b0);
    send_frame(ByteW'($urandom), 16'(lim) + 16'd1, 1'b0);
    run_traffic(20);
  endtask

  // Output ready: random stalls, or a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        rx_ready <= 1'b0;
        rx_hold--;
      end else if (rx_stall > 0) begin
        rx_ready <= 1'b0;
        rx_stall--;
      end else if (!rx_idle_en) begin
        rx_ready <= 1'b1;
      end else begin
        rx_stall = gap_len();
        rx_ready <= (rx_stall == 0);
        if (rx_stall > 0) rx_stall--;
      end
    end
  end

  task automatic check_field(input string name, input logic [CntW-1:0] want,
                             input logic [CntW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  // Compare each taken result with the oldest pending status
  always @(posedge clk_i) begin : status_check
    rx_status_t want;
    if (rst_ni && m_axis_tvalid && rx_ready) begin
      if (pending_q.size() == 0) begin
        $error("result with no pending status");
        n_errors++;
      end else begin
        want = pending_q.pop_front();
        check_field("frame_good", CntW'(want.good), CntW'(m_axis_tuser[0]));
        check_field("checksum_bad", CntW'(want.sum_bad), CntW'(m_axis_tuser[1]));
        check_field("length_bad", CntW'(want.len_bad), CntW'(m_axis_tuser[2]));
        check_field("frame_type", CntW'(want.ftype), CntW'(m_axis_tdata[7:0]));
        check_field("frame_length", CntW'(want.flen), CntW'(m_axis_tdata[18:8]));
        check_field("read_data", CntW'(want.rdata), CntW'(m_axis_tdata[26:19]));
        check_field("good_count", want.n_good, m_axis_tdata[58:27]);
        check_field("bad_checksum_count", want.n_sum_bad, m_axis_tdata[90:59]);
        check_field("bad_length_count", want.n_len_bad, m_axis_tdata[122:91]);
      end
    end
  end

  initial begin
    #(TimeoutNs);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_largest_frame();
    test_random_traffic();
    test_no_idle();
    test_back_pressure();
    test_equal_sync();
    test_limit_cap();
    test_small_limit();
    wait_idle();
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> frame_deframer_xor_checksum_top.f
rtl/fdx_pkg.sv
rtl/fdx_rx.sv
rtl/frame_deframer_xor_checksum_top.sv
bench/tb_frame_deframer_xor_checksum_top.sv
